// ===== hdl/msp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID package
// Shared widths, register indexes, reset values and inter-stage types.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int NUM_MOTORS   = 4;
    localparam int MOTOR_W      = 2;
    localparam int MOTOR_SLOTS  = 2 ** MOTOR_W;
    localparam int SPEED_W      = 16;
    localparam int GAIN_W       = 16;
    localparam int ERR_LIM_W    = 14;
    localparam int INT_LIM_W    = 15;
    localparam int CUR_LIM_W    = 15;
    localparam int ERR_W        = 15;
    localparam int SUM_W        = 16;
    localparam int DIFF_W       = 16;
    localparam int PROD_P_W     = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W     = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W     = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W        = 35;
    localparam int FRAC_W       = 8;
    localparam int DRIVE_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [GAIN_W-1:0]    KP_RESET      = 16'd2304;
    localparam logic [GAIN_W-1:0]    KI_RESET      = 16'd179;
    localparam logic [GAIN_W-1:0]    KD_RESET      = 16'd0;
    localparam logic [ERR_LIM_W-1:0] ERR_LIM_RESET = 14'd5000;
    localparam logic [INT_LIM_W-1:0] INT_LIM_RESET = 15'd15000;
    localparam logic [CUR_LIM_W-1:0] CUR_LIM_RESET = 15'd15000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_KD      = 3'd2,
        CFG_ERR_LIM = 3'd3,
        CFG_INT_LIM = 3'd4,
        CFG_CUR_LIM = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]    kp;
        logic [GAIN_W-1:0]    ki;
        logic [GAIN_W-1:0]    kd;
        logic [ERR_LIM_W-1:0] err_lim;
        logic [INT_LIM_W-1:0] int_lim;
        logic [CUR_LIM_W-1:0] cur_lim;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [MOTOR_W-1:0] motor;
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] measured;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic              bad;
        logic [ERR_W-1:0]  e;
        logic [SUM_W-1:0]  s;
        logic [DIFF_W-1:0] d;
    } t_err;

    typedef struct packed {
        logic                valid;
        logic                bad;
        logic [PROD_P_W-1:0] p;
        logic [PROD_I_W-1:0] i;
        logic [PROD_D_W-1:0] d;
    } t_prod;

    typedef struct packed {
        logic               valid;
        logic [DRIVE_W-1:0] drive;
        logic               sat;
    } t_res;

endpackage

// ===== hdl/msp_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID configuration registers
// Gains and limits, written one register per request.
// ----------------------------------------------------------------------------
module msp_cfg
    import msp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:      n_cfg.kp      = i_cfg_data;
                CFG_KI:      n_cfg.ki      = i_cfg_data;
                CFG_KD:      n_cfg.kd      = i_cfg_data;
                CFG_ERR_LIM: n_cfg.err_lim = i_cfg_data[ERR_LIM_W-1:0];
                CFG_INT_LIM: n_cfg.int_lim = i_cfg_data[INT_LIM_W-1:0];
                CFG_CUR_LIM: n_cfg.cur_lim = i_cfg_data[CUR_LIM_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp      <= KP_RESET;
            r_cfg.ki      <= KI_RESET;
            r_cfg.kd      <= KD_RESET;
            r_cfg.err_lim <= ERR_LIM_RESET;
            r_cfg.int_lim <= INT_LIM_RESET;
            r_cfg.cur_lim <= CUR_LIM_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hdl/msp_err.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID error stage
// Clamps the speed error, updates the per-motor error sum and previous error.
// ----------------------------------------------------------------------------
module msp_err
    import msp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_err  o_err
);

    logic [SUM_W-1:0] r_sum  [MOTOR_SLOTS];
    logic [ERR_W-1:0] r_prev [MOTOR_SLOTS];
    t_err             r_err;
    t_err             n_err;

    logic signed [SPEED_W:0] w_diff;
    logic signed [SPEED_W:0] w_elim;
    logic signed [SPEED_W:0] w_ec;
    logic signed [SUM_W:0]   w_sum;
    logic signed [SUM_W:0]   w_ilim;
    logic signed [SUM_W:0]   w_sc;
    logic                    w_bad;
    logic                    w_upd;

    assign w_bad  = ({{(32-MOTOR_W){1'b0}}, i_item.motor} >= 32'(NUM_MOTORS));
    assign w_diff = $signed({i_item.target[SPEED_W-1], i_item.target})
                  - $signed({i_item.measured[SPEED_W-1], i_item.measured});
    assign w_elim = $signed({{(SPEED_W+1-ERR_LIM_W){1'b0}}, i_cfg.err_lim});
    assign w_ec   = (w_diff > w_elim) ? w_elim : ((w_diff < -w_elim) ? -w_elim : w_diff);

    assign w_sum  = $signed({r_sum[i_item.motor][SUM_W-1], r_sum[i_item.motor]})
                  + $signed({{(SUM_W+1-ERR_W){w_ec[ERR_W-1]}}, w_ec[ERR_W-1:0]});
    assign w_ilim = $signed({{(SUM_W+1-INT_LIM_W){1'b0}}, i_cfg.int_lim});
    assign w_sc   = (w_sum > w_ilim) ? w_ilim : ((w_sum < -w_ilim) ? -w_ilim : w_sum);

    assign w_upd  = i_load && i_item.valid && !w_bad;

    always_comb begin
        n_err.valid = i_item.valid;
        n_err.bad   = w_bad;
        n_err.e     = w_ec[ERR_W-1:0];
        n_err.s     = w_sc[SUM_W-1:0];
        n_err.d     = {w_ec[ERR_W-1], w_ec[ERR_W-1:0]}
                    - {r_prev[i_item.motor][ERR_W-1], r_prev[i_item.motor]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err.valid <= 1'b0;
            for (int k = 0; k < MOTOR_SLOTS; k++) begin
                r_sum[k]  <= '0;
                r_prev[k] <= '0;
            end
        end else begin
            if (i_load) begin
                r_err <= n_err;
            end
            if (w_upd) begin
                r_sum[i_item.motor]  <= n_err.s;
                r_prev[i_item.motor] <= n_err.e;
            end
        end
    end

    assign o_err = r_err;

endmodule

// ===== hdl/msp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID product stage
// Forms the proportional, integral and derivative products in parallel.
// ----------------------------------------------------------------------------
module msp_mul
    import msp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_err  i_err,
    input  t_cfg  i_cfg,
    output t_prod o_prod
);

    t_prod r_prod;
    t_prod n_prod;

    always_comb begin
        n_prod.valid = i_err.valid;
        n_prod.bad   = i_err.bad;
        n_prod.p     = PROD_P_W'($signed({1'b0, i_cfg.kp}) * $signed(i_err.e));
        n_prod.i     = PROD_I_W'($signed({1'b0, i_cfg.ki}) * $signed(i_err.s));
        n_prod.d     = PROD_D_W'($signed({1'b0, i_cfg.kd}) * $signed(i_err.d));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/msp_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID output stage
// Sums the products, truncates toward zero and clamps to the current limit.
// ----------------------------------------------------------------------------
module msp_sat
    import msp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_prod i_prod,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    t_res r_res;
    t_res n_res;

    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_mag;
    logic signed [ACC_W-1:0] w_whole;
    logic        [ACC_W-1:0] w_lim_q;
    logic                    w_neg;
    logic                    w_sat;
    logic        [DRIVE_W-1:0] w_lim;

    assign w_acc   = ACC_W'($signed(i_prod.p)) + ACC_W'($signed(i_prod.i))
                   + ACC_W'($signed(i_prod.d));
    assign w_neg   = w_acc[ACC_W-1];
    assign w_mag   = w_neg ? -w_acc : w_acc;
    assign w_lim_q = {{(ACC_W-CUR_LIM_W-FRAC_W){1'b0}}, i_cfg.cur_lim, {FRAC_W{1'b0}}};
    assign w_sat   = $unsigned(w_mag) > w_lim_q;
    assign w_whole = w_neg ? ((w_acc + ACC_W'(signed'(255))) >>> FRAC_W) : (w_acc >>> FRAC_W);
    assign w_lim   = {1'b0, i_cfg.cur_lim};

    always_comb begin
        n_res.valid = i_prod.valid;
        if (i_prod.bad) begin
            n_res.drive = '0;
            n_res.sat   = 1'b0;
        end else if (w_sat) begin
            n_res.drive = w_neg ? -w_lim : w_lim;
            n_res.sat   = 1'b1;
        end else begin
            n_res.drive = w_whole[DRIVE_W-1:0];
            n_res.sat   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== hdl/motor_speed_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID
// Positional PID speed loop with anti-windup clamp, shared by several motors.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while no back-pressure holds it,
// and returns one result per request, in order. A request passes the input
// register, error stage (which also updates the motor's error sum and
// previous error), product stage and output stage, whose register holds the
// result. Back-to-back requests for the same motor see each other's state,
// because the state update completes within the error stage. Empty stages are
// filled while a result waits to be taken, so up to four requests can be held.
// ----------------------------------------------------------------------------
module motor_speed_pid
    import msp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // motor_index[1:0], target_speed[17:2], measured_speed[33:18], zero[39:34]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // drive_current[15:0]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // current_saturated[0]
    output logic [0:0]             o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg  w_cfg;
    t_item r_in;
    t_err  w_err;
    t_prod w_prod;
    t_res  w_res;
    logic  w_en_in;
    logic  w_en_err;
    logic  w_en_mul;
    logic  w_en_out;

    assign w_en_out = !w_res.valid || i_m_axis_tready;
    assign w_en_mul = !w_prod.valid || w_en_out;
    assign w_en_err = !w_err.valid || w_en_mul;
    assign w_en_in  = !r_in.valid || w_en_err;

    assign o_s_axis_tready = w_en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en_in) begin
            r_in.valid    <= i_s_axis_tvalid;
            r_in.motor    <= i_s_axis_tdata[MOTOR_W-1:0];
            r_in.target   <= i_s_axis_tdata[MOTOR_W +: SPEED_W];
            r_in.measured <= i_s_axis_tdata[MOTOR_W+SPEED_W +: SPEED_W];
        end
    end

    msp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    msp_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_en_err),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_err   (w_err)
    );

    msp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_en_mul),
        .i_err   (w_err),
        .i_cfg   (w_cfg),
        .o_prod  (w_prod)
    );

    msp_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_en_out),
        .i_prod  (w_prod),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_m_axis_tvalid   = w_res.valid;
    assign o_m_axis_tdata    = w_res.drive;
    assign o_m_axis_tuser[0] = w_res.sat;

    a_err_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in.valid && w_en_err) |=>
        (($signed({w_err.e[ERR_W-1], w_err.e}) <= $signed({2'b00, $past(w_cfg.err_lim)})) &&
         ($signed({w_err.e[ERR_W-1], w_err.e}) >= -$signed({2'b00, $past(w_cfg.err_lim)}))))
        else $error("Clamped error exceeds the error limit.");

    a_sum_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in.valid && w_en_err) |=>
        (($signed({w_err.s[SUM_W-1], w_err.s}) <= $signed({2'b00, $past(w_cfg.int_lim)})) &&
         ($signed({w_err.s[SUM_W-1], w_err.s}) >= -$signed({2'b00, $past(w_cfg.int_lim)}))))
        else $error("Error sum exceeds the integral limit.");

    a_bad_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_prod.valid && w_prod.bad && w_en_out) |=>
        (o_m_axis_tdata == '0 && !o_m_axis_tuser[0]))
        else $error("Request for an absent motor produced a drive.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result valid directly after reset.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed PID testbench
// Drives speed requests through the stream input with random gaps, predicts
// each drive current from a model of the per-motor PID state, and checks
// every result as it leaves the block under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_CUR_LIM + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_CUR_LIM + 2);

    typedef struct {
        logic [DRIVE_W-1:0] drive;
        logic               sat;
    } t_drive_pred;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]             o_m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [GAIN_W-1:0]    kp_q;
    logic [GAIN_W-1:0]    ki_q;
    logic [GAIN_W-1:0]    kd_q;
    logic [ERR_LIM_W-1:0] err_lim_q;
    logic [INT_LIM_W-1:0] int_lim_q;
    logic [CUR_LIM_W-1:0] cur_lim_q;
    int                   loop_sum [NUM_MOTORS];
    int                   loop_prev [NUM_MOTORS];

    t_drive_pred pending_drive[$];
    int          error_count;
    int          cycle_count;
    int          rx_hold_cycles;
    bit          quiet;

    motor_speed_pid dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_mag(int v, int lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    task automatic predict_drive(input logic [MOTOR_W-1:0] motor,
                                 input logic signed [SPEED_W-1:0] tgt,
                                 input logic signed [SPEED_W-1:0] meas);
        int          err;
        int          sum;
        longint      kp_l;
        longint      ki_l;
        longint      kd_l;
        longint      lim_l;
        longint      acc;
        longint      mag;
        longint      whole;
        t_drive_pred res;
        kp_l  = kp_q;
        ki_l  = ki_q;
        kd_l  = kd_q;
        lim_l = cur_lim_q;
        err   = clamp_mag(int'(tgt) - int'(meas), int'(err_lim_q));
        sum   = clamp_mag(loop_sum[motor] + err, int'(int_lim_q));
        loop_sum[motor] = sum;
        acc = kp_l * err + ki_l * sum + kd_l * (err - loop_prev[motor]);
        loop_prev[motor] = err;
        mag     = (acc < 0) ? -acc : acc;
        res.sat = (mag > lim_l * 256);
        if (res.sat) begin
            whole = (acc < 0) ? -lim_l : lim_l;
        end else begin
            whole = acc / 256;
        end
        res.drive = whole[DRIVE_W-1:0];
        pending_drive.push_back(res);
    endtask

    task automatic send_speed(input logic [MOTOR_W-1:0] motor,
                              input logic signed [SPEED_W-1:0] tgt,
                              input logic signed [SPEED_W-1:0] meas);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, meas, tgt, motor};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_drive(motor, tgt, meas);
    endtask

    task automatic idle_sender();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KP: begin
                kp_q = value;
            end
            CFG_KI: begin
                ki_q = value;
            end
            CFG_KD: begin
                kd_q = value;
            end
            CFG_ERR_LIM: begin
                err_lim_q = value[ERR_LIM_W-1:0];
            end
            CFG_INT_LIM: begin
                int_lim_q = value[INT_LIM_W-1:0];
            end
            CFG_CUR_LIM: begin
                cur_lim_q = value[CUR_LIM_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] kp, ki, kd,
                             input logic [CFG_DATA_W-1:0] err_lim, int_lim, cur_lim);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_ERR_LIM, err_lim);
        write_reg(CFG_INT_LIM, int_lim);
        write_reg(CFG_CUR_LIM, cur_lim);
    endtask

    task automatic drain_results();
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // The receiver stalls at random, and holds off entirely while a hold-off
    // count is pending.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_drive_pred exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_drive.size() == 0) begin
                $error("drive_current result arrived with no request outstanding: %0d",
                       $signed(o_m_axis_tdata));
                error_count++;
            end else begin
                exp_res = pending_drive.pop_front();
                if (o_m_axis_tdata !== exp_res.drive) begin
                    $error("drive_current mismatch: expected %0d, actual %0d",
                           $signed(exp_res.drive), $signed(o_m_axis_tdata));
                    error_count++;
                end
                if (o_m_axis_tuser[0] !== exp_res.sat) begin
                    $error("current_saturated mismatch: expected %0d, actual %0d",
                           exp_res.sat, o_m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    task automatic test_reset_values();
        send_speed(2'd0, 16'sd0, 16'sd0);
        send_speed(2'd1, 16'sh7FFF, -16'sh8000);
        send_speed(2'd2, -16'sh8000, 16'sh7FFF);
        send_speed(2'd3, 16'sd1000, 16'sd900);
        send_speed(2'd3, 16'sd1000, 16'sd900);
        send_speed(2'd0, -16'sd12, 16'sd12);
        idle_sender();
        drain_results();
    endtask

    task automatic test_register_extremes();
        // Limits written all ones must be cut to their register widths.
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'h0000);
        write_reg(CFG_SPARE_B, 16'h0000);
        send_speed(2'd0, 16'sh7FFF, -16'sh8000);
        send_speed(2'd0, -16'sh8000, 16'sh7FFF);
        send_speed(2'd1, -16'sh8000, 16'sh7FFF);
        idle_sender();
        drain_results();

        // A result exactly at the current limit is not saturated.
        write_all(16'd256, 16'd0, 16'd0, 16'd16383, 16'd32767, 16'd100);
        send_speed(2'd2, 16'sd100, 16'sd0);
        send_speed(2'd2, 16'sd101, 16'sd0);
        send_speed(2'd2, -16'sd101, 16'sd0);
        idle_sender();
        drain_results();

        // Fractions below one whole unit truncate towards zero.
        write_reg(CFG_KP, 16'd1);
        write_reg(CFG_CUR_LIM, 16'd32767);
        send_speed(2'd3, 16'sd100, 16'sd0);
        send_speed(2'd3, -16'sd100, 16'sd0);
        send_speed(2'd3, 16'sd0, 16'sd300);
        idle_sender();
        drain_results();

        write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_speed(2'd1, 16'sh7FFF, -16'sh8000);
        idle_sender();
        drain_results();
    endtask

    task automatic test_backpressure();
        quiet = 1'b1;
        rx_hold_cycles = 300;
        repeat (40) begin
            send_speed(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
        end
        quiet = 1'b0;
        idle_sender();
        drain_results();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg(int hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end else if (r == 2) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, hi));
    endfunction

    task automatic test_random_traffic();
        logic [MOTOR_W-1:0]        motor;
        logic signed [SPEED_W-1:0] tgt;
        logic signed [SPEED_W-1:0] meas;
        int                        delta;
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 0) begin
                write_all('1, '1, '1, '1, '1, '1);
            end else begin
                write_all(pick_reg(4096), pick_reg(1024), pick_reg(2048),
                          pick_reg(16383), pick_reg(32767), pick_reg(16384));
            end
            quiet = ($urandom_range(0, 3) == 0);
            repeat (200) begin
                motor = 2'($urandom_range(0, 3));
                tgt   = 16'($urandom);
                if ($urandom_range(0, 4) != 0) begin
                    delta = $urandom_range(0, 1200) - 600;
                    meas  = 16'(int'(tgt) + delta);
                end else begin
                    meas = 16'($urandom);
                end
                send_speed(motor, tgt, meas);
            end
            quiet = 1'b0;
            idle_sender();
            drain_results();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        error_count     = 0;
        rx_hold_cycles  = 0;
        quiet           = 1'b0;
        kp_q            = KP_RESET;
        ki_q            = KI_RESET;
        kd_q            = KD_RESET;
        err_lim_q       = ERR_LIM_RESET;
        int_lim_q       = INT_LIM_RESET;
        cur_lim_q       = CUR_LIM_RESET;
        for (int m = 0; m < NUM_MOTORS; m++) begin
            loop_sum[m]  = 0;
            loop_prev[m] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        drain_results();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
